// ----- rtl/thumb_to_microop_cracker_defines.svh -----
// assertion macros for the micro-op cracker
`ifndef THUMB_TO_MICROOP_CRACKER_DEFINES_SVH
`define THUMB_TO_MICROOP_CRACKER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define TMC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define TMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tmc_pkg.sv -----
`timescale 1ns / 1ps
package tmc_pkg;

	// micro-op kinds
	localparam logic [4:0] K_LOADIMM = 5'd0;
	localparam logic [4:0] K_MOVE    = 5'd1;
	localparam logic [4:0] K_ADD     = 5'd2;
	localparam logic [4:0] K_SUB     = 5'd3;
	localparam logic [4:0] K_LSL     = 5'd4;
	localparam logic [4:0] K_LSR     = 5'd5;
	localparam logic [4:0] K_ASR     = 5'd6;
	localparam logic [4:0] K_AND     = 5'd7;
	localparam logic [4:0] K_XOR     = 5'd8;
	localparam logic [4:0] K_OR      = 5'd9;
	localparam logic [4:0] K_NOT     = 5'd10;
	localparam logic [4:0] K_ADC     = 5'd11;
	localparam logic [4:0] K_SBC     = 5'd12;
	localparam logic [4:0] K_CMP     = 5'd13;
	localparam logic [4:0] K_JUMP    = 5'd14;
	localparam logic [4:0] K_LOADLIT = 5'd15;
	localparam logic [4:0] K_END     = 5'd16;

	localparam logic [3:0] COND_ALWAYS = 4'd14;

	// flag mask bits
	localparam logic [7:0] F_KV    = 8'h01;
	localparam logic [7:0] F_KC    = 8'h02;
	localparam logic [7:0] F_WV    = 8'h10;
	localparam logic [7:0] F_WC    = 8'h20;
	localparam logic [7:0] F_WZ    = 8'h40;
	localparam logic [7:0] F_WN    = 8'h80;
	localparam logic [7:0] F_ARITH = F_WV | F_WC | F_WZ | F_WN;
	localparam logic [7:0] F_LOGIC = F_KV | F_KC | F_WZ | F_WN;

	// request kinds
	localparam logic REQ_START  = 1'b0;
	localparam logic REQ_DECODE = 1'b1;

	// configuration register indexes
	localparam logic CFG_SEQ    = 1'b0;
	localparam logic CFG_NONSEQ = 1'b1;

	localparam int unsigned CFG_DATA_W = 4;

	// one cracked micro-op
	typedef struct packed {
		logic [4:0]  kind;
		logic [3:0]  src_a;
		logic [3:0]  src_b;
		logic [3:0]  dest_reg;
		logic [31:0] imm;
		logic [5:0]  cost;
		logic [1:0]  len;
		logic [7:0]  flags;
		logic        block_end;
		logic        last;
	} uop_t;

endpackage

// ----- rtl/tmc_req_if.sv -----
`timescale 1ns / 1ps
interface tmc_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [15:0] opcode;
	logic [31:0] start_pc;

	modport source (output valid, output req_type, output opcode, output start_pc,
		input ready);
	modport sink (input valid, input req_type, input opcode, input start_pc,
		output ready);
endinterface

// ----- rtl/tmc_uop_if.sv -----
`timescale 1ns / 1ps
interface tmc_uop_if;
	logic        valid;
	logic        ready;
	logic [4:0]  uop_kind;
	logic [3:0]  src_a;
	logic [3:0]  src_b;
	logic [3:0]  dest_reg;
	logic [31:0] imm_value;
	logic [5:0]  cycle_cost;
	logic [1:0]  source_len;
	logic [7:0]  flag_mask;
	logic        block_end;
	logic        last;

	modport source (output valid, output uop_kind, output src_a, output src_b,
		output dest_reg, output imm_value, output cycle_cost, output source_len,
		output flag_mask, output block_end, output last, input ready);
	modport sink (input valid, input uop_kind, input src_a, input src_b,
		input dest_reg, input imm_value, input cycle_cost, input source_len,
		input flag_mask, input block_end, input last, output ready);
endinterface

// ----- rtl/thumb_to_microop_cracker.sv -----
`timescale 1ns / 1ps
// the first micro-op of an accepted halfword is registered into the result buffer
// throughput: one halfword per cycle while each cracks to a single micro-op and the sink is ready;
// a two-op halfword fills the two-entry result buffer, and the next halfword is taken as its second op leaves
// start and ignored transactions give no micro-op
// reset: async active low, clears pc, branch bound, block open flag, buffer count;
// fetch cost registers reset to 1
module thumb_to_microop_cracker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [tmc_pkg::CFG_DATA_W-1:0]  cfg_data,
	tmc_req_if.sink                         req,
	tmc_uop_if.source                       rsp
);
	import tmc_pkg::*;
	`include "thumb_to_microop_cracker_defines.svh"

	logic [3:0]  seq_q;
	logic [3:0]  nonseq_q;
	logic [31:0] next_pc_q;
	logic [31:0] max_tgt_q;
	logic        active_q;

	uop_t        op0_s1;
	uop_t        op1_s1;
	logic [1:0]  cnt_q;

	logic        in_fire;
	logic        out_fire;

	uop_t        d_op0;
	uop_t        d_op1;
	logic [1:0]  d_cnt;
	logic        d_ends;
	logic        d_raise;
	logic [31:0] pc;
	logic [31:0] pc_p2;
	logic [31:0] cond_tgt;
	logic [31:0] unc_tgt;
	logic [31:0] lit_addr;
	logic [5:0]  cost_s;
	logic [5:0]  cost_s1;
	logic [5:0]  cost_sn;
	logic [5:0]  cost_2sn;

	function automatic uop_t mk(input logic [4:0] kind, input logic [3:0] a,
		input logic [3:0] b, input logic [3:0] d, input logic [31:0] imm,
		input logic [5:0] cost, input logic [1:0] len, input logic [7:0] flags);
		uop_t u;
		u.kind      = kind;
		u.src_a     = a;
		u.src_b     = b;
		u.dest_reg  = d;
		u.imm       = imm;
		u.cost      = cost;
		u.len       = len;
		u.flags     = flags;
		u.block_end = 1'b0;
		u.last      = 1'b0;
		return u;
	endfunction

	// handshakes: take a new transaction when the buffer is empty or empties this cycle
	assign out_fire  = rsp.valid && rsp.ready;
	assign in_fire   = req.valid && req.ready;
	assign req.ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && rsp.ready);

	// address and cost arithmetic
	assign pc       = next_pc_q + 32'd2;
	assign pc_p2    = next_pc_q + 32'd4;
	assign cond_tgt = pc_p2 + {{23{req.opcode[7]}}, req.opcode[7:0], 1'b0};
	assign unc_tgt  = pc_p2 + {{20{req.opcode[10]}}, req.opcode[10:0], 1'b0};
	assign lit_addr = {pc_p2[31:2], 2'b00} + {22'd0, req.opcode[7:0], 2'b00};
	assign cost_s   = {2'b00, seq_q};
	assign cost_s1  = cost_s + 6'd1;
	assign cost_sn  = cost_s + {2'b00, nonseq_q};
	assign cost_2sn = cost_s + cost_sn;

	// halfword crack
	always_comb begin
		logic [15:0] op;
		logic [3:0]  rs;
		logic [3:0]  rd;
		logic [3:0]  rd_hi;
		logic [3:0]  rb;
		logic [4:0]  sh;
		logic        unsup;
		op      = req.opcode;
		rs      = {1'b0, op[5:3]} + 4'd1;
		rd      = {1'b0, op[2:0]} + 4'd1;
		rd_hi   = {1'b0, op[10:8]} + 4'd1;
		rb      = {1'b0, op[8:6]} + 4'd1;
		sh      = op[10:6];
		unsup   = 1'b0;
		d_ends  = 1'b0;
		d_raise = 1'b0;
		d_cnt   = 2'd2;
		d_op0   = mk(K_LOADIMM, 4'd0, 4'd0, 4'd0, 32'd0, 6'd0, 2'd0, 8'd0);
		d_op1   = d_op0;
		case (op[15:12])
			4'h0, 4'h1: begin
				if (op[12:11] == 2'd3) begin
					if (op[10]) begin
						d_op0 = mk(K_LOADIMM, 4'd0, 4'd0, 4'd0, {29'd0, op[8:6]},
							6'd0, 2'd0, 8'd0);
						d_op1 = mk(op[9] ? K_SUB : K_ADD, rs, 4'd0, rd, 32'd0,
							cost_s, 2'd2, F_ARITH);
					end else begin
						d_cnt = 2'd1;
						d_op0 = mk(op[9] ? K_SUB : K_ADD, rs, rb, rd, 32'd0,
							cost_s, 2'd2, F_ARITH);
					end
				end else if (op[12:11] == 2'd0) begin
					d_op0 = mk(K_LOADIMM, 4'd0, 4'd0, 4'd0, {27'd0, sh}, 6'd0, 2'd0, 8'd0);
					d_op1 = mk(K_LSL, rs, 4'd0, rd, 32'd0, cost_s, 2'd2,
						F_KV | ((sh != 5'd0) ? F_WC : F_KC) | F_WZ | F_WN);
				end else begin
					d_op0 = mk(K_LOADIMM, 4'd0, 4'd0, 4'd0,
						(sh != 5'd0) ? {27'd0, sh} : 32'd32, 6'd0, 2'd0, 8'd0);
					d_op1 = mk(op[12] ? K_ASR : K_LSR, rs, 4'd0, rd, 32'd0, cost_s,
						2'd2, F_KV | F_WC | F_WZ | F_WN);
				end
			end
			4'h2, 4'h3: begin
				d_op0 = mk(K_LOADIMM, 4'd0, 4'd0, 4'd0, {24'd0, op[7:0]}, 6'd0, 2'd0, 8'd0);
				case (op[12:11])
					2'd0:    d_op1 = mk(K_MOVE, 4'd0, 4'd0, rd_hi, 32'd0, cost_s, 2'd2,
						F_LOGIC);
					2'd1:    d_op1 = mk(K_CMP, rd_hi, 4'd0, 4'd0, 32'd0, cost_s, 2'd2,
						F_ARITH);
					2'd2:    d_op1 = mk(K_ADD, rd_hi, 4'd0, rd_hi, 32'd0, cost_s, 2'd2,
						F_ARITH);
					default: d_op1 = mk(K_SUB, rd_hi, 4'd0, rd_hi, 32'd0, cost_s, 2'd2,
						F_ARITH);
				endcase
			end
			4'h4: begin
				if (op[11]) begin
					d_op0 = mk(K_LOADLIT, 4'd0, 4'd0, 4'd0, lit_addr, 6'd0, 2'd0, 8'd0);
					d_op1 = mk(K_MOVE, 4'd0, 4'd0, rd_hi, 32'd0, cost_s1, 2'd2, 8'd0);
				end else if (op[10]) begin
					unsup = 1'b1;
				end else begin
					d_cnt = 2'd1;
					case (op[9:6])
						4'h0: d_op0 = mk(K_AND, rd, rs, rd, 32'd0, cost_s, 2'd2, F_LOGIC);
						4'h1: d_op0 = mk(K_XOR, rd, rs, rd, 32'd0, cost_s, 2'd2, F_LOGIC);
						4'h5: d_op0 = mk(K_ADC, rd, rs, rd, 32'd0, cost_s, 2'd2, F_ARITH);
						4'h6: d_op0 = mk(K_SBC, rd, rs, rd, 32'd0, cost_s, 2'd2, F_ARITH);
						4'h8: d_op0 = mk(K_AND, rd, rs, 4'd0, 32'd0, cost_s, 2'd2, F_LOGIC);
						4'h9: begin
							d_cnt = 2'd2;
							d_op1 = mk(K_SUB, 4'd0, rs, rd, 32'd0, cost_s, 2'd2, F_ARITH);
						end
						4'hA: d_op0 = mk(K_CMP, rd, rs, 4'd0, 32'd0, cost_s, 2'd2, F_ARITH);
						4'hB: d_op0 = mk(K_ADD, rd, rs, 4'd0, 32'd0, cost_s, 2'd2, F_ARITH);
						4'hC: d_op0 = mk(K_OR, rd, rs, rd, 32'd0, cost_s, 2'd2, F_LOGIC);
						4'hE: begin
							d_cnt = 2'd2;
							d_op0 = mk(K_NOT, rs, 4'd0, 4'd0, 32'd0, 6'd0, 2'd0, 8'd0);
							d_op1 = mk(K_AND, rd, 4'd0, rd, 32'd0, cost_s, 2'd2, F_LOGIC);
						end
						4'hF: d_op0 = mk(K_NOT, rs, 4'd0, rd, 32'd0, cost_s, 2'd2, F_LOGIC);
						default: unsup = 1'b1;
					endcase
				end
			end
			4'hD: begin
				if (op[11:9] == 3'b111) begin
					// undefined condition and software interrupt
					unsup = 1'b1;
				end else begin
					d_op0   = mk(K_LOADIMM, 4'd0, 4'd0, 4'd0, cond_tgt, cost_s, 2'd0, 8'd0);
					d_op1   = mk(K_JUMP, op[11:8], 4'd0, 4'd0, 32'd0, cost_sn, 2'd2, 8'd0);
					d_raise = cond_tgt > max_tgt_q;
				end
			end
			4'hE: begin
				d_op0  = mk(K_LOADIMM, 4'd0, 4'd0, 4'd0, unc_tgt, 6'd0, 2'd0, 8'd0);
				d_op1  = mk(K_JUMP, COND_ALWAYS, 4'd0, 4'd0, 32'd0, cost_2sn, 2'd2, 8'd0);
				d_ends = pc > max_tgt_q;
			end
			default: unsup = 1'b1;
		endcase
		if (unsup) begin
			d_cnt   = 2'd1;
			d_ends  = 1'b1;
			d_raise = 1'b0;
			d_op0   = mk(K_END, 4'd0, 4'd0, 4'd0, next_pc_q, 6'd0, 2'd0, 8'd0);
		end
		d_op0.block_end = d_ends;
		d_op1.block_end = d_ends;
		d_op0.last      = (d_cnt == 2'd1);
		d_op1.last      = 1'b1;
		// start items and halfwords outside an open block give nothing
		if ((req.req_type == REQ_START) || !active_q) begin
			d_cnt = 2'd0;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q    <= 4'd1;
			nonseq_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SEQ:    seq_q    <= cfg_data;
				CFG_NONSEQ: nonseq_q <= cfg_data;
				default:    seq_q    <= seq_q;
			endcase
		end
	end

	// block tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_pc_q <= 32'd0;
			max_tgt_q <= 32'd0;
			active_q  <= 1'b0;
		end else if (in_fire) begin
			if (req.req_type == REQ_START) begin
				next_pc_q <= req.start_pc;
				max_tgt_q <= req.start_pc;
				active_q  <= 1'b1;
			end else if (active_q) begin
				next_pc_q <= pc;
				if (d_raise) begin
					max_tgt_q <= cond_tgt;
				end
				if (d_ends) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	// result buffer occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (in_fire && (d_cnt != 2'd0)) begin
			cnt_q <= d_cnt;
		end else if (out_fire) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// result buffer payload, second op moves up when the first leaves
	always_ff @(posedge clk) begin
		if (in_fire && (d_cnt != 2'd0)) begin
			op0_s1 <= d_op0;
			op1_s1 <= d_op1;
		end else if (out_fire && (cnt_q == 2'd2)) begin
			op0_s1 <= op1_s1;
		end
	end

	// output channel
	assign rsp.valid      = (cnt_q != 2'd0);
	assign rsp.uop_kind   = op0_s1.kind;
	assign rsp.src_a      = op0_s1.src_a;
	assign rsp.src_b      = op0_s1.src_b;
	assign rsp.dest_reg   = op0_s1.dest_reg;
	assign rsp.imm_value  = op0_s1.imm;
	assign rsp.cycle_cost = op0_s1.cost;
	assign rsp.source_len = op0_s1.len;
	assign rsp.flag_mask  = op0_s1.flags;
	assign rsp.block_end  = op0_s1.block_end;
	assign rsp.last       = op0_s1.last;

	// checks
	`TMC_ASSERT_NOW(a_no_overrun, in_fire, (cnt_q == 2'd0) || out_fire, "buffer overrun")
	`TMC_ASSERT_NOW(a_last_matches, rsp.valid, op0_s1.last == (cnt_q == 2'd1), "last flag mismatch")
	`TMC_ASSERT_NOW(a_fall_on_decode, $fell(active_q), $past(in_fire) && $past(req.req_type == REQ_DECODE), "block closed without decode")
	`TMC_ASSERT_NEXT(a_start_opens, in_fire && (req.req_type == REQ_START), active_q && (next_pc_q == $past(req.start_pc)), "start did not open block")

endmodule

// ----- sim/tb_thumb_to_microop_cracker.sv -----
`timescale 1ns / 1ps
module tb_thumb_to_microop_cracker;
	import tmc_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic sink_ready = 1'b0;
	logic calm = 1'b0;

	tmc_req_if req_ch ();
	tmc_uop_if uop_ch ();

	assign uop_ch.ready = sink_ready;

	thumb_to_microop_cracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (uop_ch)
	);

	always #5 clk = ~clk;

	// predictor state, mirrors the block
	logic [31:0] pc_next = 32'd0;
	logic [31:0] branch_bound = 32'd0;
	logic block_open = 1'b0;
	logic [3:0] seq_cost = 4'd1;
	logic [3:0] nonseq_cost = 4'd1;

	uop_t expected_uops [$];
	uop_t cracked [2];
	int n_cracked;

	int n_fail = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_blocks = 0;
	int n_closed = 0;
	int n_ignored = 0;
	int n_settings = 0;

	function automatic void emit(logic [4:0] kind, logic [3:0] a, logic [3:0] b,
		logic [3:0] d, logic [31:0] imm, logic [5:0] cost, logic [1:0] len,
		logic [7:0] flags);
		if (n_cracked < 2) begin
			cracked[n_cracked] = '{kind, a, b, d, imm, cost, len, flags, 1'b0, 1'b0};
			n_cracked++;
		end
	endfunction

	// crack one accepted transaction into its expected micro-ops
	function automatic void crack_item(logic rt, logic [15:0] op, logic [31:0] spc);
		logic unsup;
		logic ends;
		logic [31:0] iaddr, pc, tgt, off;
		logic [5:0] s, nn;
		logic [3:0] ra, rd, rb, r8;
		logic [4:0] sh;
		unsup = 1'b0;
		ends = 1'b0;
		n_cracked = 0;
		if (rt == REQ_START) begin
			pc_next = spc;
			branch_bound = spc;
			block_open = 1'b1;
			n_blocks++;
			return;
		end
		if (!block_open) begin
			n_ignored++;
			return;
		end
		iaddr = pc_next;
		pc = iaddr + 32'd2;
		pc_next = pc;
		s = {2'b00, seq_cost};
		nn = {2'b00, nonseq_cost};
		ra = {1'b0, op[5:3]} + 4'd1;
		rd = {1'b0, op[2:0]} + 4'd1;
		r8 = {1'b0, op[10:8]} + 4'd1;
		sh = op[10:6];
		case (op[15:12])
			4'h0, 4'h1: begin
				if (op[12:11] == 2'd3) begin
					rb = 4'd0;
					if (op[10])
						emit(K_LOADIMM, 0, 0, 0, {29'd0, op[8:6]}, 0, 0, 0);
					else
						rb = {1'b0, op[8:6]} + 4'd1;
					emit(op[9] ? K_SUB : K_ADD, ra, rb, rd, 0, s, 2'd2, F_ARITH);
				end else if (op[12:11] == 2'd0) begin
					emit(K_LOADIMM, 0, 0, 0, {27'd0, sh}, 0, 0, 0);
					emit(K_LSL, ra, 0, rd, 0, s, 2'd2,
						F_KV | ((sh != 0) ? F_WC : F_KC) | F_WZ | F_WN);
				end else begin
					emit(K_LOADIMM, 0, 0, 0, (sh != 0) ? {27'd0, sh} : 32'd32, 0, 0, 0);
					emit(op[12] ? K_ASR : K_LSR, ra, 0, rd, 0, s, 2'd2,
						F_KV | F_WC | F_WZ | F_WN);
				end
			end
			4'h2, 4'h3: begin
				emit(K_LOADIMM, 0, 0, 0, {24'd0, op[7:0]}, 0, 0, 0);
				case (op[12:11])
					2'd0: emit(K_MOVE, 0, 0, r8, 0, s, 2'd2, F_LOGIC);
					2'd1: emit(K_CMP, r8, 0, 0, 0, s, 2'd2, F_ARITH);
					2'd2: emit(K_ADD, r8, 0, r8, 0, s, 2'd2, F_ARITH);
					default: emit(K_SUB, r8, 0, r8, 0, s, 2'd2, F_ARITH);
				endcase
			end
			4'h4: begin
				if (op[11]) begin
					tgt = ((pc + 32'd2) & ~32'd3) + {22'd0, op[7:0], 2'b00};
					emit(K_LOADLIT, 0, 0, 0, tgt, 0, 0, 0);
					emit(K_MOVE, 0, 0, r8, 0, s + 6'd1, 2'd2, 0);
				end else if (op[10]) begin
					unsup = 1'b1;
				end else begin
					case (op[9:6])
						4'h0: emit(K_AND, rd, ra, rd, 0, s, 2'd2, F_LOGIC);
						4'h1: emit(K_XOR, rd, ra, rd, 0, s, 2'd2, F_LOGIC);
						4'h5: emit(K_ADC, rd, ra, rd, 0, s, 2'd2, F_ARITH);
						4'h6: emit(K_SBC, rd, ra, rd, 0, s, 2'd2, F_ARITH);
						4'h8: emit(K_AND, rd, ra, 0, 0, s, 2'd2, F_LOGIC);
						4'h9: begin
							emit(K_LOADIMM, 0, 0, 0, 0, 0, 0, 0);
							emit(K_SUB, 0, ra, rd, 0, s, 2'd2, F_ARITH);
						end
						4'hA: emit(K_CMP, rd, ra, 0, 0, s, 2'd2, F_ARITH);
						4'hB: emit(K_ADD, rd, ra, 0, 0, s, 2'd2, F_ARITH);
						4'hC: emit(K_OR, rd, ra, rd, 0, s, 2'd2, F_LOGIC);
						4'hE: begin
							emit(K_NOT, ra, 0, 0, 0, 0, 0, 0);
							emit(K_AND, rd, 0, rd, 0, s, 2'd2, F_LOGIC);
						end
						4'hF: emit(K_NOT, ra, 0, rd, 0, s, 2'd2, F_LOGIC);
						default: unsup = 1'b1;
					endcase
				end
			end
			4'hD: begin
				// conditions 14 and 15 are not branches
				if (op[11:8] >= 4'd14) begin
					unsup = 1'b1;
				end else begin
					off = {{24{op[7]}}, op[7:0]};
					tgt = pc + 32'd2 + (off << 1);
					emit(K_LOADIMM, 0, 0, 0, tgt, s, 0, 0);
					emit(K_JUMP, op[11:8], 0, 0, 0, s + nn, 2'd2, 0);
					if (tgt > branch_bound)
						branch_bound = tgt;
				end
			end
			4'hE: begin
				off = {{21{op[10]}}, op[10:0]};
				emit(K_LOADIMM, 0, 0, 0, pc + 32'd2 + (off << 1), 0, 0, 0);
				emit(K_JUMP, COND_ALWAYS, 0, 0, 0, (s << 1) + nn, 2'd2, 0);
				// leaving the block unless a forward branch still lands past here
				if (pc > branch_bound)
					ends = 1'b1;
			end
			default: unsup = 1'b1;
		endcase
		if (unsup) begin
			n_cracked = 0;
			emit(K_END, 0, 0, 0, iaddr, 0, 0, 0);
			ends = 1'b1;
		end
		if (ends) begin
			block_open = 1'b0;
			n_closed++;
		end
		for (int k = 0; k < n_cracked; k++) begin
			cracked[k].block_end = ends;
			cracked[k].last = (k == n_cracked - 1);
			expected_uops.push_back(cracked[k]);
		end
	endfunction

	function automatic string fmt_uop(uop_t u);
		return $sformatf("kind=%0d a=%0d b=%0d d=%0d imm=%08h cost=%0d len=%0d flags=%02h end=%0b last=%0b",
			u.kind, u.src_a, u.src_b, u.dest_reg, u.imm, u.cost, u.len, u.flags,
			u.block_end, u.last);
	endfunction

	// result side: random back-pressure and in-order compare
	always @(posedge clk) begin
		uop_t got, want;
		logic bad;
		sink_ready <= calm || ($urandom_range(99) >= 22);
		if (arst_n && uop_ch.valid && sink_ready) begin
			got = '{uop_ch.uop_kind, uop_ch.src_a, uop_ch.src_b, uop_ch.dest_reg,
				uop_ch.imm_value, uop_ch.cycle_cost, uop_ch.source_len, uop_ch.flag_mask,
				uop_ch.block_end, uop_ch.last};
			if (expected_uops.size() == 0) begin
				n_fail++;
				if (n_fail <= 10)
					$display("%0t unexpected micro-op: %s", $realtime, fmt_uop(got));
			end else begin
				want = expected_uops.pop_front();
				n_checked++;
				bad = (got.kind !== want.kind) || (got.src_a !== want.src_a)
					|| (got.src_b !== want.src_b) || (got.dest_reg !== want.dest_reg)
					|| (got.imm !== want.imm) || (got.cost !== want.cost)
					|| (got.len !== want.len) || (got.flags !== want.flags)
					|| (got.block_end !== want.block_end) || (got.last !== want.last);
				if (bad) begin
					n_fail++;
					if (n_fail <= 10) begin
						$display("%0t micro-op mismatch", $realtime);
						$display("  expected %s", fmt_uop(want));
						$display("  actual   %s", fmt_uop(got));
					end
				end
			end
		end
	end

	// one request transaction; valid stays high after acceptance
	task automatic send_req(logic rt, logic [15:0] op, logic [31:0] spc);
		if (!calm) begin
			while ($urandom_range(99) < 22) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rt;
		req_ch.opcode <= op;
		req_ch.start_pc <= spc;
		do
			@(posedge clk);
		while (!req_ch.ready);
		n_sent++;
		crack_item(rt, op, spc);
	endtask

	// stop sending and let every pending micro-op drain
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (expected_uops.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_fetch_costs(logic [3:0] seq, logic [3:0] nonseq);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_SEQ;
		cfg_data <= seq;
		@(posedge clk);
		cfg_index <= CFG_NONSEQ;
		cfg_data <= nonseq;
		@(posedge clk);
		cfg_we <= 1'b0;
		seq_cost = seq;
		nonseq_cost = nonseq;
		n_settings++;
		@(posedge clk);
	endtask

	function automatic logic [15:0] rand_halfword();
		logic [31:0] r;
		logic [3:0] cond;
		int pick;
		r = $urandom();
		pick = $urandom_range(99);
		cond = ($urandom_range(19) == 0) ? 4'(14 + $urandom_range(1)) : 4'($urandom_range(13));
		if (pick < 18)
			return {3'b000, r[12:0]};
		else if (pick < 34)
			return {3'b001, r[12:0]};
		else if (pick < 54)
			return {6'b010000, r[9:0]};
		else if (pick < 62)
			return {5'b01001, r[10:0]};
		else if (pick < 76)
			return {4'hD, cond, r[7:0]};
		else if (pick < 84)
			return {5'b11100, r[10:0]};
		else if (pick < 90)
			return {6'b010001, r[9:0]};
		return r[15:0];
	endfunction

	function automatic logic [31:0] rand_start_pc();
		logic [31:0] r;
		int pick;
		r = $urandom();
		pick = $urandom_range(99);
		if (pick < 15)
			r = {24'hFFFFFF, r[7:0]};
		else if (pick < 25)
			r = {24'h000000, r[7:0]};
		if ($urandom_range(4) != 0)
			r[0] = 1'b0;
		return r;
	endfunction

	// mostly well-formed blocks, with restarts and halfwords sent to a closed block
	task automatic send_random_halfwords(int count);
		int done;
		done = 0;
		while (done < count) begin
			if (!block_open && $urandom_range(9) == 0) begin
				send_req(REQ_DECODE, rand_halfword(), $urandom());
			end else if (!block_open || $urandom_range(49) == 0) begin
				send_req(REQ_START, 16'($urandom()), rand_start_pc());
				done++;
			end else begin
				send_req(REQ_DECODE, rand_halfword(), $urandom());
				done++;
			end
		end
	endtask

	// shifts by zero and 31, register and immediate add/sub, near address wrap
	task automatic test_shift_and_addsub();
		send_req(REQ_START, 16'hFFFF, 32'hFFFF_FFFC);
		send_req(REQ_DECODE, 16'h0000, 32'h0);
		send_req(REQ_DECODE, 16'h07FF, 32'hFFFF_FFFF);
		send_req(REQ_DECODE, 16'h0800, 32'h0);
		send_req(REQ_DECODE, 16'h17FF, 32'h0);
		send_req(REQ_DECODE, 16'h1800, 32'h0);
		send_req(REQ_DECODE, 16'h1FFF, 32'h0);
	endtask

	// mov/cmp/add/sub immediate and a pc-relative load at the widest offset
	task automatic test_immediates_and_literal();
		send_req(REQ_DECODE, 16'h20FF, 32'h0);
		send_req(REQ_DECODE, 16'h2F00, 32'h0);
		send_req(REQ_DECODE, 16'h3000, 32'h0);
		send_req(REQ_DECODE, 16'h3FFF, 32'h0);
		send_req(REQ_DECODE, 16'h4FFF, 32'h0);
	endtask

	// and, neg, cmn, bic, mvn, then mul which closes the block
	task automatic test_register_alu();
		send_req(REQ_DECODE, 16'h4000, 32'h0);
		send_req(REQ_DECODE, 16'h4240, 32'h0);
		send_req(REQ_DECODE, 16'h42C0, 32'h0);
		send_req(REQ_DECODE, 16'h4380, 32'h0);
		send_req(REQ_DECODE, 16'h43FF, 32'h0);
		send_req(REQ_DECODE, 16'h4340, 32'h0);
	endtask

	// halfword with no open block, branches, and every way a block closes
	task automatic test_branches_and_block_end();
		send_req(REQ_DECODE, 16'h2000, 32'h0);
		send_req(REQ_START, 16'h0000, 32'hFFFF_FFFF);
		send_req(REQ_DECODE, 16'hD07F, 32'h0);
		send_req(REQ_DECODE, 16'hE000, 32'h0);
		send_req(REQ_DECODE, 16'hDE00, 32'h0);
		send_req(REQ_START, 16'h0000, 32'h0000_0100);
		send_req(REQ_DECODE, 16'hD480, 32'h0);
		send_req(REQ_DECODE, 16'hE7FF, 32'h0);
		send_req(REQ_START, 16'h0000, 32'h0000_0000);
		send_req(REQ_DECODE, 16'hFFFF, 32'h0);
	endtask

	// fetch cost extremes and one random setting, random blocks under each
	task automatic test_fetch_costs();
		logic [3:0] seq_vals [5] = '{4'd0, 4'd15, 4'd0, 4'd15, 4'd1};
		logic [3:0] nonseq_vals [5] = '{4'd0, 4'd15, 4'd15, 4'd0, 4'd1};
		for (int i = 0; i < 5; i++) begin
			set_fetch_costs(seq_vals[i], nonseq_vals[i]);
			send_random_halfwords(250);
		end
		set_fetch_costs(4'($urandom()), 4'($urandom()));
		send_random_halfwords(250);
	endtask

	// no idling on either side
	task automatic test_back_to_back();
		calm = 1'b1;
		send_random_halfwords(300);
		calm = 1'b0;
	endtask

	// short bursts, each drained before the next
	task automatic test_pause_for_drain();
		repeat (10) begin
			send_random_halfwords($urandom_range(10, 30));
			wait_idle();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_SEQ;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_START;
		req_ch.opcode <= '0;
		req_ch.start_pc <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_shift_and_addsub();
		test_immediates_and_literal();
		test_register_alu();
		test_branches_and_block_end();
		test_fetch_costs();
		test_back_to_back();
		test_pause_for_drain();

		// drain, then give late micro-ops a chance to show up
		req_ch.valid <= 1'b0;
		for (int i = 0; i < 5000 && expected_uops.size() != 0; i++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (expected_uops.size() != 0) begin
			n_fail++;
			$display("%0d expected micro-ops never arrived", expected_uops.size());
		end

		$display("sent %0d transactions over %0d fetch cost settings, checked %0d micro-ops",
			n_sent, n_settings, n_checked);
		$display("opened %0d blocks, closed %0d, %0d halfwords ignored, %0d failures",
			n_blocks, n_closed, n_ignored, n_fail);
		if (n_fail == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog
	initial begin
		#(2_000_000);
		$display("watchdog expired, %0d micro-ops still pending", expected_uops.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
